[rtl/core/itda_pkg.sv]
// ----------------------------------------------------------------------------
// itda_pkg - shared definitions for the integer to decimal ascii converter
// sizes, character codes, kind decoding, sequencer states and command structs
// ----------------------------------------------------------------------------
package itda_pkg;

   localparam int VALUE_WIDTH   = 64;
   localparam int MAX_DIGITS    = 20;
   localparam int BCD_WIDTH     = 4 * MAX_DIGITS;
   localparam int CNT_WIDTH     = $clog2(VALUE_WIDTH + 1);
   localparam int IDX_WIDTH     = $clog2(VALUE_WIDTH);
   localparam int DIG_CNT_WIDTH = $clog2(MAX_DIGITS + 1);

   localparam int DATA_WIDTH    = 64;
   localparam int KIND_WIDTH    = 3;
   localparam int KIND_SIGNED   = 2;
   localparam int SYMBOL_WIDTH  = 8;

   localparam logic [SYMBOL_WIDTH-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [SYMBOL_WIDTH-1:0] ASCII_NINE  = 8'h39;
   localparam logic [SYMBOL_WIDTH-1:0] ASCII_MINUS = 8'h2d;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_TRIM,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // commands from the sequencer to the shift-and-add-3 unit
   typedef struct packed {
      logic load;
      logic step;
      logic roll;
   } bcd_cmd_type;

   // operand width in bits for the size field of kind
   function automatic logic [CNT_WIDTH-1:0] kind_width(input logic [1:0] size);
      int w;
      begin
         w = 8 << size;
         if (w > VALUE_WIDTH) begin
            w = VALUE_WIDTH;
         end
         return CNT_WIDTH'(w);
      end
   endfunction

endpackage

[rtl/core/integer_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii - integer to decimal text converter
// ----------------------------------------------------------------------------
// Request channel (req_): tdata carries the raw integer, tuser the kind code
// (bit 2 signed, bits 1:0 select 8, 16, 32 or 64 bits). Only the low bits of
// the selected width are used, sign- or zero-extended.
// Response channel (rsp_): one ascii character per transfer, '-' first for a
// negative value, then the digits without leading zeros; tlast marks the
// final digit. Zero gives the single character '0'.
// Sequence: a request is taken, then the shift-and-add-3 unit runs one step
// per operand bit, then leading zero digits are dropped one per cycle, then
// one character leaves per cycle while the receiver takes them. req_tready is
// high only while no conversion is under way; the last character may still
// wait in the output register at that time.
// A stalled receiver holds the sequencer until the character is taken.
// Reset is synchronous and returns the block to idle with no result pending.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [itda_pkg::DATA_WIDTH-1:0]     req_tdata,   // [63:0] value
   input  logic [itda_pkg::KIND_WIDTH-1:0]     req_tuser,   // [2:0] kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [itda_pkg::SYMBOL_WIDTH-1:0]   rsp_tdata,   // [7:0] symbol
   output logic                                rsp_tlast
);

   itda_pkg::bcd_cmd_type              cmd;
   logic [itda_pkg::VALUE_WIDTH-1:0]   load_value;
   logic [3:0]                         top_digit;

   itda_bcd_unit u_bcd_unit (
      .clock      (clock),
      .cmd        (cmd),
      .load_value (load_value),
      .top_digit  (top_digit)
   );

   itda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .load_value (load_value),
      .top_digit  (top_digit)
   );

   // busy for the whole conversion once a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a conversion is under way");

   // only a sign or a digit ever leaves
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == itda_pkg::ASCII_MINUS) ||
                     ((rsp_tdata >= itda_pkg::ASCII_ZERO) &&
                      (rsp_tdata <= itda_pkg::ASCII_NINE)))
      else $error("character outside sign and digits");

   // a sign is always followed by digits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == itda_pkg::ASCII_MINUS) |-> !rsp_tlast)
      else $error("sign marked as final character");

   // when idle only the final character of the previous number may be pending
   assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("ready for a request with the number unfinished");

endmodule

[rtl/core/itda_bcd_unit.sv]
// ----------------------------------------------------------------------------
// itda_bcd_unit - shared shift-and-add-3 converter
// one binary bit per step moves into a packed bcd register; the bcd register
// can also roll out its top digit one nibble at a time
// ----------------------------------------------------------------------------
module itda_bcd_unit (
   input  logic                                clock,
   input  itda_pkg::bcd_cmd_type               cmd,
   input  logic [itda_pkg::VALUE_WIDTH-1:0]    load_value,
   output logic [3:0]                          top_digit
);

   logic [itda_pkg::BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [itda_pkg::VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [itda_pkg::BCD_WIDTH-1:0]   adjusted;

   // add 3 to every digit of 5 or more before the doubling
   always_comb begin
      for (int d = 0; d < itda_pkg::MAX_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            adjusted[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            adjusted[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      bin_in = bin_ff;
      if (cmd.load) begin
         bcd_in = '0;
         bin_in = load_value;
      end else if (cmd.step) begin
         bcd_in = {adjusted[itda_pkg::BCD_WIDTH-2:0], bin_ff[itda_pkg::VALUE_WIDTH-1]};
         bin_in = {bin_ff[itda_pkg::VALUE_WIDTH-2:0], 1'b0};
      end else if (cmd.roll) begin
         bcd_in = {bcd_ff[itda_pkg::BCD_WIDTH-5:0], 4'h0};
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   assign top_digit = bcd_ff[itda_pkg::BCD_WIDTH-1 -: 4];

endmodule

[rtl/core/itda_ctrl.sv]
// ----------------------------------------------------------------------------
// itda_ctrl - sequencer and result register
// takes a request, prepares the magnitude, runs the converter, drops leading
// zero digits and sends the sign and digits out one character at a time
// ----------------------------------------------------------------------------
module itda_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [itda_pkg::DATA_WIDTH-1:0]       req_tdata,
   input  logic [itda_pkg::KIND_WIDTH-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [itda_pkg::SYMBOL_WIDTH-1:0]     rsp_tdata,
   output logic                                  rsp_tlast,
   output itda_pkg::bcd_cmd_type                 cmd,
   output logic [itda_pkg::VALUE_WIDTH-1:0]      load_value,
   input  logic [3:0]                            top_digit
);

   itda_pkg::state_type state_ff, state_in;

   logic [itda_pkg::CNT_WIDTH-1:0]     iter_ff, iter_in;
   logic [itda_pkg::DIG_CNT_WIDTH-1:0] digits_ff, digits_in;
   logic                               negative_ff, negative_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [itda_pkg::SYMBOL_WIDTH-1:0]  rsp_symbol_ff, rsp_symbol_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic                               accept;
   logic                               out_free;
   logic                               out_load;
   logic                               last_digit;
   logic                               top_zero;

   logic [itda_pkg::CNT_WIDTH-1:0]     width;
   logic [itda_pkg::IDX_WIDTH-1:0]     sign_idx;
   logic [itda_pkg::VALUE_WIDTH-1:0]   mask;
   logic [itda_pkg::VALUE_WIDTH-1:0]   raw;
   logic [itda_pkg::VALUE_WIDTH-1:0]   mag;
   logic                               negative;

   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_digit = (digits_ff == itda_pkg::DIG_CNT_WIDTH'(1));
   assign top_zero   = (top_digit == 4'h0);

   // extend the selected width, take the magnitude, align it to the top
   always_comb begin
      width    = itda_pkg::kind_width(req_tuser[1:0]);
      sign_idx = itda_pkg::IDX_WIDTH'(width - itda_pkg::CNT_WIDTH'(1));
      mask     = {itda_pkg::VALUE_WIDTH{1'b1}} >> (itda_pkg::VALUE_WIDTH - int'(width));
      raw      = req_tdata[itda_pkg::VALUE_WIDTH-1:0] & mask;
      negative = req_tuser[itda_pkg::KIND_SIGNED] && raw[sign_idx];
      if (negative) begin
         mag = (~raw + itda_pkg::VALUE_WIDTH'(1)) & mask;
      end else begin
         mag = raw;
      end
      load_value = mag << (itda_pkg::VALUE_WIDTH - int'(width));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itda_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = itda_pkg::ST_CONV;
            end
         end
         itda_pkg::ST_CONV: begin
            if (iter_ff == itda_pkg::CNT_WIDTH'(1)) begin
               state_in = itda_pkg::ST_TRIM;
            end
         end
         itda_pkg::ST_TRIM: begin
            if (!top_zero || last_digit) begin
               state_in = negative_ff ? itda_pkg::ST_SIGN : itda_pkg::ST_EMIT;
            end
         end
         itda_pkg::ST_SIGN: begin
            if (out_free) begin
               state_in = itda_pkg::ST_EMIT;
            end
         end
         itda_pkg::ST_EMIT: begin
            if (out_free && last_digit) begin
               state_in = itda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itda_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      out_load      = 1'b0;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         itda_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         itda_pkg::ST_CONV: begin
            cmd.step = 1'b1;
         end
         itda_pkg::ST_TRIM: begin
            cmd.roll = top_zero && !last_digit;
         end
         itda_pkg::ST_SIGN: begin
            out_load = out_free;
            if (out_free) begin
               rsp_symbol_in = itda_pkg::ASCII_MINUS;
               rsp_last_in   = 1'b0;
            end
         end
         itda_pkg::ST_EMIT: begin
            out_load = out_free;
            cmd.roll = out_free;
            if (out_free) begin
               rsp_symbol_in = itda_pkg::ASCII_ZERO + {4'h0, top_digit};
               rsp_last_in   = last_digit;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      iter_in      = iter_ff;
      digits_in    = digits_ff;
      negative_in  = negative_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         iter_in     = width;
         digits_in   = itda_pkg::DIG_CNT_WIDTH'(itda_pkg::MAX_DIGITS);
         negative_in = negative;
      end
      if (cmd.step) begin
         iter_in = iter_ff - itda_pkg::CNT_WIDTH'(1);
      end
      if (cmd.roll) begin
         digits_in = digits_ff - itda_pkg::DIG_CNT_WIDTH'(1);
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
         digits_ff    <= '0;
         negative_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
         digits_ff    <= digits_in;
         negative_ff  <= negative_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_symbol_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
